// ----- rtl/ptw_pkg.sv -----
// shared types, constants and address helpers for the page table walker
// no dependencies; imported by page_table_walker_core, its checker and its testbench
package ptw_pkg;

    localparam int STORE_WORDS = 4096;                 // power of two, 16 .. 1M
    localparam int ADDR_W      = $clog2(STORE_WORDS);

    localparam int PA_W        = 52;
    localparam int VA_W        = 48;
    localparam int ENT_W       = 64;
    localparam int IDX_W       = 9;
    localparam int FRAME_W     = 40;                   // frame number, bits 51..12

    localparam int TDATA_IN_W  = 216;                  // 52 + 48 + 52 + 64, whole bytes
    localparam int TDATA_OUT_W = 56;                   // 52 bits padded to 7 bytes

    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    typedef logic [ADDR_W-1:0]  t_waddr;
    typedef logic [ENT_W-1:0]   t_entry;
    typedef logic [VA_W-1:0]    t_va;
    typedef logic [PA_W-1:0]    t_pa;
    typedef logic [FRAME_W-1:0] t_frame;
    typedef logic [IDX_W-1:0]   t_idx;

    // 9-bit table index of the virtual address for a given level
    function automatic t_idx level_index(input t_va va, input logic [1:0] lvl);
        t_idx idx;
        case (lvl)
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            LVL_PT:   idx = va[20:12];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

    // word address of entry idx in the table at frame, wrapping over the store
    function automatic t_waddr table_word(input t_frame frame, input t_idx idx);
        logic [FRAME_W+IDX_W-1:0] sum;
        sum = {frame, {IDX_W{1'b0}}} + {{FRAME_W{1'b0}}, idx};
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/page_table_walker_core.sv -----
// page table walker: four-level walk over an on-chip store of 64-bit entries
// a write answers straight from the request; a translate reads one to four levels first
// throughput: one transaction in flight; next accepted once its result register can drain
// each level costs one read of the single-port synchronous table store
// reset (synchronous, i_rst_n low) clears control, then a pass over all 4096 words zeroes the
// store one word per cycle with s_axis_tready low; depends on ptw_pkg
module page_table_walker_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // root_table[51:0], virt_addr[99:52], entry_addr[151:100], entry_value[215:152]
    input  logic [ptw_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
    // opcode
    input  logic                                s_axis_tuser,
    // result side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // phys_addr[51:0], zero padding[55:52]
    output logic [ptw_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
    // fault
    output logic                                m_axis_tuser
);
    import ptw_pkg::*;

    // controller states
    localparam logic [1:0] S_CLEAR = 2'd0;   // zeroing pass after reset
    localparam logic [1:0] S_IDLE  = 2'd1;   // waiting for a transaction
    localparam logic [1:0] S_WALK  = 2'd2;   // entry of r_level is in r_rdata

    // table store and its registered read port
    t_entry mem_store [STORE_WORDS];
    t_entry r_rdata;

    // control state
    logic [1:0] r_state, n_state;
    logic [1:0] r_level, n_level;
    t_waddr     r_clr_addr, n_clr_addr;
    t_va        r_va, n_va;
    logic       r_m_valid, n_m_valid;
    t_pa        r_pa, n_pa;
    logic       r_fault, n_fault;

    // store access for this cycle
    logic       w_we;
    t_waddr     w_waddr;
    t_entry     w_wdata;
    logic       w_re;
    t_waddr     w_raddr;

    // request fields
    t_pa        w_root;
    t_va        w_va_in;
    t_pa        w_entry_addr;
    t_entry     w_entry_value;
    logic       w_in_acc;
    logic       w_out_free;

    // walk evaluation of the returned entry
    logic       w_present;
    logic       w_large;
    logic       w_done;
    t_pa        w_walk_pa;
    logic [1:0] w_next_level;

    assign w_root        = s_axis_tdata[51:0];
    assign w_va_in       = s_axis_tdata[99:52];
    assign w_entry_addr  = s_axis_tdata[151:100];
    assign w_entry_value = s_axis_tdata[215:152];

    // result register can take a new value this cycle
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign w_present    = r_rdata[PRESENT_BIT];
    // large bit counts only at the 1 GiB and 2 MiB levels
    assign w_large      = r_rdata[LARGE_BIT] && (r_level == LVL_PDPT || r_level == LVL_PD);
    assign w_done       = !w_present || w_large || (r_level == LVL_PT);
    assign w_next_level = r_level + 2'd1;

    // translated address for a walk that ends at this level
    always_comb begin
        case (r_level)
            LVL_PDPT: w_walk_pa = {r_rdata[51:30], r_va[29:0]};
            LVL_PD:   w_walk_pa = {r_rdata[51:21], r_va[20:0]};
            default:  w_walk_pa = {r_rdata[51:12], r_va[11:0]};
        endcase
        if (!w_present) begin
            w_walk_pa = '0;
        end
    end

    // sequencer: clear pass, request intake, one level per cycle of the walk
    always_comb begin
        n_state    = r_state;
        n_level    = r_level;
        n_clr_addr = r_clr_addr;
        n_va       = r_va;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_pa       = r_pa;
        n_fault    = r_fault;
        w_we       = 1'b0;
        w_waddr    = r_clr_addr;
        w_wdata    = '0;
        w_re       = 1'b0;
        w_raddr    = table_word(w_root[51:12], level_index(w_va_in, LVL_PML4));

        case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                n_clr_addr = r_clr_addr + t_waddr'(1);
                if (r_clr_addr == t_waddr'(STORE_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == OP_WRITE) begin
                        // store the entry and answer at once with a zero result
                        w_we      = 1'b1;
                        w_waddr   = w_entry_addr[ADDR_W+2:3];
                        w_wdata   = w_entry_value;
                        n_m_valid = 1'b1;
                        n_pa      = '0;
                        n_fault   = 1'b0;
                    end else begin
                        // top-level read issued from the request itself
                        w_re    = 1'b1;
                        n_va    = w_va_in;
                        n_level = LVL_PML4;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (w_done) begin
                    // r_rdata holds still while the result register is busy
                    if (w_out_free) begin
                        n_m_valid = 1'b1;
                        n_pa      = w_walk_pa;
                        n_fault   = !w_present;
                        n_state   = S_IDLE;
                    end
                end else begin
                    w_re    = 1'b1;
                    w_raddr = table_word(r_rdata[51:12], level_index(r_va, w_next_level));
                    n_level = w_next_level;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // writes and reads never fall in the same cycle, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_store[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rdata <= mem_store[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_level    <= LVL_PML4;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_level    <= n_level;
            r_m_valid  <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_va    <= n_va;
        r_pa    <= n_pa;
        r_fault <= n_fault;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(TDATA_OUT_W - PA_W){1'b0}}, r_pa};
    assign m_axis_tuser  = r_fault;

`ifndef SYNTHESIS
    a_no_intake_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("request accepted during store clearing pass");

    a_write_answers_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tuser == OP_WRITE) |=> (r_m_valid && r_pa == '0 && !r_fault))
        else $error("entry write did not produce a zero result");

    a_fault_has_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_fault) |-> (r_pa == '0))
        else $error("faulting translation with nonzero address");

    a_walk_steps_one_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && !w_done) |=> (r_state == S_WALK && r_level == $past(r_level) + 2'd1))
        else $error("walk level did not advance by one");

    a_no_read_with_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("store read and write in the same cycle");
`endif

endmodule

// ----- test/page_table_walker_core_checker.sv -----
// scoreboard for page_table_walker_core: mirrors the table store, predicts each result
// and compares it with the result stream; depends on ptw_pkg
`timescale 1ns / 1ps

module page_table_walker_core_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [ptw_pkg::TDATA_IN_W-1:0]  i_req_data,
    input  logic                            i_req_op,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [ptw_pkg::TDATA_OUT_W-1:0] i_rsp_data,
    input  logic                            i_rsp_fault,
    output int                              o_errors,
    output int                              o_pending
);
    import ptw_pkg::*;

    // request field offsets inside tdata
    localparam int RT_LSB = 0;
    localparam int VA_LSB = 52;
    localparam int EA_LSB = 100;
    localparam int EV_LSB = 152;

    localparam logic [63:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] PA_MASK    = 64'h000F_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [PA_W-1:0] pa;
        logic            flt;
    } t_xlat;

    t_entry tbl_mirror [STORE_WORDS];
    t_xlat  xlat_q [$];
    t_xlat  want;
    int     err_count = 0;

    assign o_errors = err_count;

    task automatic report_bad(input string what, input logic [63:0] got,
                              input logic [63:0] exp_val);
        $display("%0t ns: %s: got %h, want %h", $time, what, got, exp_val);
        err_count++;
    endtask

    // four-level walk over the mirrored store
    function automatic t_xlat walk_tables(input logic [PA_W-1:0] root, input t_va va);
        logic [63:0] base;
        logic [63:0] ent;
        logic [63:0] pmask;
        logic [63:0] word;
        logic [63:0] page;
        int          lvl;
        int          shift;
        t_xlat       res;
        base = {12'h000, root} & FRAME_MASK;
        res  = '0;
        for (lvl = 0; lvl < 4; lvl++) begin
            shift = 39 - 9 * lvl;
            word  = (base >> 3) + (({16'h0000, va} >> shift) & 64'h1FF);
            ent   = tbl_mirror[word[ADDR_W-1:0]];
            if (!ent[PRESENT_BIT]) begin
                res.flt = 1'b1;
                return res;
            end
            // large page only honored at the middle two levels
            if ((lvl == 1 || lvl == 2) && ent[LARGE_BIT]) begin
                pmask  = (64'd1 << shift) - 64'd1;
                page   = ((ent & FRAME_MASK & ~pmask) | ({16'h0000, va} & pmask)) & PA_MASK;
                res.pa = page[PA_W-1:0];
                return res;
            end
            base = ent & FRAME_MASK;
        end
        res.pa = base[PA_W-1:0] | {40'h0, va[11:0]};
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (tbl_mirror[i]) tbl_mirror[i] = '0;
            xlat_q.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (xlat_q.size() == 0) begin
                    report_bad("result with nothing outstanding",
                               {8'h00, i_rsp_data}, '0);
                end else begin
                    want = xlat_q.pop_front();
                    if (i_rsp_data[PA_W-1:0] !== want.pa)
                        report_bad("phys_addr", {12'h000, i_rsp_data[PA_W-1:0]},
                                   {12'h000, want.pa});
                    if (i_rsp_fault !== want.flt)
                        report_bad("fault", {63'h0, i_rsp_fault}, {63'h0, want.flt});
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_op == OP_WRITE) begin
                    tbl_mirror[i_req_data[EA_LSB+ADDR_W+2:EA_LSB+3]] =
                        i_req_data[EV_LSB+ENT_W-1:EV_LSB];
                    xlat_q.push_back('0);
                end else begin
                    xlat_q.push_back(walk_tables(i_req_data[RT_LSB+PA_W-1:RT_LSB],
                                                 i_req_data[VA_LSB+VA_W-1:VA_LSB]));
                end
            end
        end
        o_pending <= xlat_q.size();
    end

endmodule

// ----- test/page_table_walker_core_tb.sv -----
// testbench top for page_table_walker_core: clock, reset, request and ready stimulus,
// watchdog and verdict; depends on ptw_pkg, page_table_walker_core and page_table_walker_core_checker
`timescale 1ns / 1ps

module page_table_walker_core_tb;
    import ptw_pkg::*;

    localparam int N_ITEMS    = 1350;
    localparam int IDLE_LIMIT = 20000;   // covers the store clear pass after reset

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // root_table[51:0], virt_addr[99:52], entry_addr[151:100], entry_value[215:152]
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
    // opcode
    logic                   s_axis_tuser  = OP_WRITE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // phys_addr[51:0], zero padding[55:52]
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    // fault
    logic                   m_axis_tuser;

    int          err_count;
    int          pending;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    bit          no_idle     = 1'b0;     // stretches with no gaps on either side
    logic [51:0] last_root   = '0;       // reused so random translates hit built tables

    always #5 i_clk = ~i_clk;

    page_table_walker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    page_table_walker_core_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_op    (s_axis_tuser),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_data  (m_axis_tdata),
        .i_rsp_fault (m_axis_tuser),
        .o_errors    (err_count),
        .o_pending   (pending)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [51:0] rand52();
        logic [63:0] r;
        r = rand64();
        return r[51:0];
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = rand64();
        return r[47:0];
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // each of the four level bits set with the given percentage
    function automatic logic [3:0] draw_flags(input int pct);
        logic [3:0] f;
        for (int i = 0; i < 4; i++) f[i] = ($urandom_range(0, 99) < pct);
        return f;
    endfunction

    function automatic logic [TDATA_IN_W-1:0] pack_req(input logic [51:0] root,
                                                       input logic [47:0] va,
                                                       input logic [51:0] eaddr,
                                                       input logic [63:0] evalue);
        return {evalue, eaddr, va, root};
    endfunction

    // one request transaction; valid stays high on return unless the next call idles
    task automatic send_req(input logic op, input logic [TDATA_IN_W-1:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // hold requests off until every outstanding result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // build a full four-level path for a random va, then translate it
    // present/lpage give the flag bits per level (bit 0 = top level)
    task automatic walk_sequence(input logic [3:0] present, input logic [3:0] lpage,
                                 input bit extra);
        logic [51:0] root;
        logic [47:0] va;
        logic [39:0] frame;
        logic [63:0] ent;
        logic [63:0] r;
        logic [51:0] eaddr;
        logic [8:0]  idx;
        root  = rand52();
        va    = rand48();
        frame = root[51:12];
        for (int lvl = 0; lvl < 4; lvl++) begin
            idx           = va[47 - 9 * lvl -: 9];
            ent           = rand64();
            ent[0]        = present[lvl];
            ent[7]        = lpage[lvl];
            eaddr         = {frame, 12'h000} + {40'h0, idx, 3'b000};
            r             = rand64();
            eaddr[2:0]    = r[39:37];
            // store wraps, so upper address bits may be anything
            if (r[63]) eaddr[51:15] = r[36:0];
            send_req(OP_WRITE, pack_req(rand52(), rand48(), eaddr, ent));
            frame = ent[51:12];
        end
        last_root = root;
        send_req(OP_TRANSLATE, pack_req(root, va, rand52(), rand64()));
        // second va sharing the upper levels
        if (extra) begin
            r        = rand64();
            va[20:0] = r[20:0];
            send_req(OP_TRANSLATE, pack_req(root, va, rand52(), rand64()));
        end
    endtask

    // receiver: random stalls on the result side
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) stall_left <= draw_gap();
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int iter;
        int pick;
        iter = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store faults at the top level, for zero and all-ones inputs
        send_req(OP_TRANSLATE, pack_req('0, '0, rand52(), rand64()));
        send_req(OP_TRANSLATE, pack_req('1, '1, rand52(), rand64()));
        // all-ones entry at the highest word, wrapped from the highest address
        send_req(OP_WRITE, pack_req(rand52(), rand48(), '1, '1));
        // same word read at both top levels, second one a 1 GiB page
        send_req(OP_TRANSLATE, pack_req('1, '1, rand52(), rand64()));
        // large bit at top and last level is ignored: 4 KiB page
        walk_sequence(4'b1111, 4'b1001, 1'b0);
        // 2 MiB and 1 GiB pages
        walk_sequence(4'b1111, 4'b0100, 1'b0);
        walk_sequence(4'b1111, 4'b0010, 1'b0);
        // fault at the last level
        walk_sequence(4'b0111, 4'b0000, 1'b0);

        // random part: mostly well-formed walks, some noise
        while (items_sent < N_ITEMS) begin
            if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
            if (iter == 120) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                walk_sequence(draw_flags(90), draw_flags(25), 1'($urandom_range(0, 1)));
            end else if (pick < 80) begin
                send_req(OP_WRITE, pack_req(rand52(), rand48(), rand52(), rand64()));
            end else if (pick < 90) begin
                send_req(OP_TRANSLATE, pack_req(rand52(), rand48(), rand52(), rand64()));
            end else begin
                send_req(OP_TRANSLATE, pack_req(last_root, rand48(), rand52(), rand64()));
            end
            iter++;
        end

        // let the last results drain, then wait on for a stray extra result
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- page_table_walker_core.f -----
rtl/ptw_pkg.sv
rtl/page_table_walker_core.sv
test/page_table_walker_core_checker.sv
test/page_table_walker_core_tb.sv
